### hdl/skf_pkg.sv
// ---------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman measurement update.
// ---------------------------------------------------------------------------
package skf_pkg;

   // fixed-point scale: one unit is 1/10000
   localparam int unsigned UNIT_SCALE = 10000;

   localparam int unsigned EST_W   = 32;   // estimate, measurement
   localparam int unsigned VAR_W   = 31;   // variances, noise terms
   localparam int unsigned PRIOR_W = 32;   // P + Q
   localparam int unsigned DEN_W   = 33;   // P + Q + R
   localparam int unsigned PROD_W  = PRIOR_W + DEN_W;  // prior * |z - x|

   // quotients never exceed 2^32, so only the low DEN_W dividend bits need steps
   localparam int unsigned DIV_STEPS = DEN_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ESTIMATE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE  = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### hdl/skf_div.sv
// ---------------------------------------------------------------------------
// skf_div
// Bit-serial restoring divider, one quotient bit per cycle, with the
// quotient rounded half away from zero (unsigned operands).
// ---------------------------------------------------------------------------
module skf_div
   import skf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [DEN_W-1:0]    divisor,
   output div_stat_type        stat,
   output logic [DEN_W-1:0]    quotient
);

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     result_ff, result_in;

   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       rem_shift;
   logic                 fits;
   logic                 round_up;

   // next partial remainder: shift in the top pending dividend bit
   assign rem_shift = {rem_ff, quo_ff[DEN_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign trial     = rem_shift - {1'b0, dvs_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, dvs_ff};

   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         // high part is already below the divisor since the quotient fits DEN_W bits
         rem_in  = {1'b0, dividend[PROD_W-1:DEN_W]};
         quo_in  = dividend[DEN_W-1:0];
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[DEN_W-2:0], fits};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end else begin
            result_in = quo_ff + DEN_W'(round_up);
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      result_ff <= result_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = result_ff;

endmodule

### hdl/scalar_kalman_update.sv
// Requests are taken one at a time, only while the sequencer is idle.
// The bit-serial divider runs two 33-step divisions per request; both are
// skipped when P+Q+R is zero.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous) clears kept estimate and variance to zero and loads
// Q = 1, R = 10000, initial estimate 0 and initial variance 10000.
// ---------------------------------------------------------------------------
// scalar_kalman_update
// One-dimensional Kalman measurement update in 1/10000 fixed point: a single
// multiplier and one shared serial divider under a small sequencer.
// ---------------------------------------------------------------------------
module scalar_kalman_update
   import skf_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EST_W-1:0]     csr_wdata,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [EST_W-1:0] req_measurement,
   input  logic                 req_restart,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [EST_W-1:0] rsp_estimate,
   output logic [VAR_W-1:0]     rsp_variance,
   output logic                 rsp_degenerate,
   output logic                 rsp_saturated
);

   localparam int CLIP_W = 50;
   localparam logic signed [CLIP_W-1:0] EST_MAX =
      (CLIP_W'(1) <<< (DATA_WIDTH - 1)) - CLIP_W'(1);
   localparam logic signed [CLIP_W-1:0] EST_MIN = -EST_MAX - CLIP_W'(1);
   localparam logic [CLIP_W-1:0] VAR_MAX = (CLIP_W'(1) << (DATA_WIDTH - 1)) - CLIP_W'(1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIOR = 3'd1;
   localparam logic [2:0] ST_DEN   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // configuration
   logic [VAR_W-1:0]        q_noise_ff;
   logic [VAR_W-1:0]        r_noise_ff;
   logic signed [EST_W-1:0] init_est_ff;
   logic [VAR_W-1:0]        init_var_ff;

   // kept state
   logic signed [EST_W-1:0] kept_est_ff, kept_est_in;
   logic [VAR_W-1:0]        kept_var_ff, kept_var_in;

   // sequencer and datapath
   logic [2:0]              state_ff, state_in;
   logic                    pass_ff, pass_in;
   logic signed [EST_W-1:0] z_ff, z_in;
   logic                    restart_ff, restart_in;
   logic signed [EST_W-1:0] xp_ff, xp_in;
   logic [PRIOR_W-1:0]      prior_ff, prior_in;
   logic signed [DEN_W-1:0] diff_ff, diff_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [DEN_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    degen_ff, degen_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DEN_W-1:0]        q_est_ff, q_est_in;
   logic [DEN_W-1:0]        q_var_ff, q_var_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [EST_W-1:0] rsp_est_ff, rsp_est_in;
   logic [VAR_W-1:0]        rsp_var_ff, rsp_var_in;
   logic                    rsp_degen_ff, rsp_degen_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic [DEN_W-1:0]        mul_b;
   logic                    div_start;
   div_stat_type            div_stat;
   logic [DEN_W-1:0]        div_quot;

   logic signed [DEN_W:0]   est_raw;
   logic signed [CLIP_W-1:0] est_wide;
   logic [CLIP_W-1:0]       var_wide;
   logic                    est_hi, est_lo, var_hi;
   logic                    load_out;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_noise_ff  <= VAR_W'(1);
         r_noise_ff  <= VAR_W'(UNIT_SCALE);
         init_est_ff <= '0;
         init_var_ff <= VAR_W'(UNIT_SCALE);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     q_noise_ff  <= csr_wdata[VAR_W-1:0];
            CSR_MEASUREMENT_NOISE: r_noise_ff  <= csr_wdata[VAR_W-1:0];
            CSR_INITIAL_ESTIMATE:  init_est_ff <= csr_wdata;
            CSR_INITIAL_VARIANCE:  init_var_ff <= csr_wdata[VAR_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier: prior * |z - x| on the first pass, prior * R on the second
   assign mul_b     = pass_ff ? {2'b00, r_noise_ff} : mag_ff;
   assign div_start = (state_ff == ST_START);

   skf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // final estimate and clipping
   always_comb begin
      if (degen_ff) begin
         est_raw = (DEN_W+1)'(xp_ff);
      end else if (neg_ff) begin
         est_raw = (DEN_W+1)'(xp_ff) - $signed({1'b0, q_est_ff});
      end else begin
         est_raw = (DEN_W+1)'(xp_ff) + $signed({1'b0, q_est_ff});
      end
      est_wide = CLIP_W'(est_raw);
      var_wide = degen_ff ? '0 : CLIP_W'(q_var_ff);
      est_hi   = est_wide > EST_MAX;
      est_lo   = est_wide < EST_MIN;
      var_hi   = var_wide > VAR_MAX;
   end

   assign load_out = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      z_in         = z_ff;
      restart_in   = restart_ff;
      xp_in        = xp_ff;
      prior_in     = prior_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      degen_in     = degen_ff;
      prod_in      = prod_ff;
      q_est_in     = q_est_ff;
      q_var_in     = q_var_ff;
      kept_est_in  = kept_est_ff;
      kept_var_in  = kept_var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_est_in   = rsp_est_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               z_in       = req_measurement;
               restart_in = req_restart;
               state_in   = ST_PRIOR;
            end
         end
         ST_PRIOR: begin
            xp_in    = restart_ff ? init_est_ff : kept_est_ff;
            prior_in = PRIOR_W'(restart_ff ? init_var_ff : kept_var_ff)
                       + PRIOR_W'(q_noise_ff);
            diff_in  = DEN_W'(z_ff) - DEN_W'(restart_ff ? init_est_ff : kept_est_ff);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = DEN_W'(prior_ff) + DEN_W'(r_noise_ff);
            neg_in   = diff_ff[DEN_W-1];
            mag_in   = diff_ff[DEN_W-1] ? DEN_W'(-diff_ff) : DEN_W'(diff_ff);
            degen_in = (DEN_W'(prior_ff) + DEN_W'(r_noise_ff)) == '0;
            pass_in  = 1'b0;
            state_in = degen_in ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(prior_ff) * PROD_W'(mul_b);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (pass_ff) begin
                  q_var_in = div_quot;
                  state_in = ST_FIN;
               end else begin
                  q_est_in = div_quot;
                  pass_in  = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_FIN: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_hi ? EST_W'(EST_MAX) :
                              est_lo ? EST_W'(EST_MIN) : est_wide[EST_W-1:0];
               rsp_var_in   = var_hi ? VAR_MAX[VAR_W-1:0] : var_wide[VAR_W-1:0];
               rsp_degen_in = degen_ff;
               rsp_sat_in   = est_hi || est_lo || var_hi;
               kept_est_in  = rsp_est_in;
               kept_var_in  = rsp_var_in;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kept_est_ff  <= '0;
         kept_var_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         kept_est_ff  <= kept_est_in;
         kept_var_ff  <= kept_var_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff         <= z_in;
      restart_ff   <= restart_in;
      xp_ff        <= xp_in;
      prior_ff     <= prior_in;
      diff_ff      <= diff_in;
      den_ff       <= den_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      degen_ff     <= degen_in;
      prod_ff      <= prod_in;
      q_est_ff     <= q_est_in;
      q_var_ff     <= q_var_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_estimate   = rsp_est_ff;
   assign rsp_variance   = rsp_var_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

### hdl/skf_checker.sv
// ---------------------------------------------------------------------------
// skf_checker
// Port-level checks for the scalar Kalman update, bound to the top level.
// ---------------------------------------------------------------------------
module skf_checker
   import skf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [EST_W-1:0] rsp_estimate,
   input logic [VAR_W-1:0]        rsp_variance,
   input logic                    rsp_degenerate
);

   // a degenerate update always clears the variance
   a_degen_var: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_variance == '0)
      else $error("degenerate result with nonzero variance");

   // one request at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate)
                                  && $stable(rsp_variance))
      else $error("stalled result changed");

endmodule

bind scalar_kalman_update skf_checker u_skf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_estimate   (rsp_estimate),
   .rsp_variance   (rsp_variance),
   .rsp_degenerate (rsp_degenerate)
);
